// File: hw/rtl/acpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared types, constants and the microcode table of the accumulator CPU
// execute block.
// ----------------------------------------------------------------------------
package acpu_pkg;

  localparam int IN_W  = 16;   // func, operand
  localparam int OUT_W = 24;   // 22 result bits, zero filled to 3 bytes

  localparam int DIV_STEPS = 8;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Status bit positions
  localparam int ST_ZERO  = 0;
  localparam int ST_CARRY = 1;
  localparam int ST_OVER  = 2;

  typedef enum logic [3:0] {
    OP_LDM  = 4'd0,
    OP_LDI  = 4'd1,
    OP_ST   = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_MUL  = 4'd5,
    OP_DIV  = 4'd6,
    OP_INC  = 4'd7,
    OP_DEC  = 4'd8,
    OP_AND  = 4'd9,
    OP_OR   = 4'd10,
    OP_NOT  = 4'd11,
    OP_JMP  = 4'd12,
    OP_JZ   = 4'd13,
    OP_JNZ  = 4'd14,
    OP_HALT = 4'd15
  } opc_t;

  // Microprogram addresses
  typedef logic [2:0] step_t;
  localparam step_t S_IDLE = 3'd0;
  localparam step_t S_DISP = 3'd1;
  localparam step_t S_EXEC = 3'd2;
  localparam step_t S_DIVI = 3'd3;
  localparam step_t S_DIVL = 3'd4;
  localparam step_t S_DIVF = 3'd5;
  localparam step_t S_DIVZ = 3'd6;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER   = 3'd0,
    C_IN      = 3'd1,
    C_DIV     = 3'd2,
    C_MZERO   = 3'd3,
    C_DIVMORE = 3'd4
  } cond_t;

  // Result source on a finishing step
  typedef enum logic [1:0] {
    RES_ALU  = 2'd0,
    RES_QUO  = 2'd1,
    RES_DIVZ = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     take;      // step accepts a request
    logic     finish;    // commit state and load the result register
    logic     div_load;  // seed the divider
    logic     div_step;  // one restoring division step
    res_sel_t res;
    cond_t    cond;
    step_t    jmp;
    step_t    nxt;
  } ctrl_t;

  typedef struct packed {
    logic is_div;
    logic m_zero;
    logic div_more;
    logic out_free;
  } dp_sts_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t cw;
    cw = '{take: 1'b0, finish: 1'b0, div_load: 1'b0, div_step: 1'b0,
           res: RES_ALU, cond: C_NEVER, jmp: S_IDLE, nxt: S_IDLE};
    case (s)
      S_IDLE: begin
        cw.take = 1'b1;
        cw.cond = C_IN;
        cw.jmp  = S_DISP;
        cw.nxt  = S_IDLE;
      end
      S_DISP: begin
        cw.cond = C_DIV;
        cw.jmp  = S_DIVI;
        cw.nxt  = S_EXEC;
      end
      S_EXEC: begin
        cw.finish = 1'b1;
        cw.res    = RES_ALU;
      end
      S_DIVI: begin
        cw.div_load = 1'b1;
        cw.cond     = C_MZERO;
        cw.jmp      = S_DIVZ;
        cw.nxt      = S_DIVL;
      end
      S_DIVL: begin
        cw.div_step = 1'b1;
        cw.cond     = C_DIVMORE;
        cw.jmp      = S_DIVL;
        cw.nxt      = S_DIVF;
      end
      S_DIVF: begin
        cw.finish = 1'b1;
        cw.res    = RES_QUO;
      end
      S_DIVZ: begin
        cw.finish = 1'b1;
        cw.res    = RES_DIVZ;
      end
      default: begin
        cw.nxt = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// File: hw/rtl/acpu_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_seq
// Microprogram sequencer: step register, control word lookup and
// conditional jumps.
// ----------------------------------------------------------------------------
module acpu_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_acc,
  input  acpu_pkg::dp_sts_t sts,
  output acpu_pkg::ctrl_t  cw
);
  import acpu_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  cond_hit;

  assign cw = ucode(step_r);

  always_comb begin
    case (cw.cond)
      C_NEVER:   cond_hit = 1'b0;
      C_IN:      cond_hit = in_acc;
      C_DIV:     cond_hit = sts.is_div;
      C_MZERO:   cond_hit = sts.m_zero;
      C_DIVMORE: cond_hit = sts.div_more;
      default:   cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cw.finish && !sts.out_free) begin
      step_nxt = step_r;          // hold until the result register frees up
    end else if (cond_hit) begin
      step_nxt = cw.jmp;
    end else begin
      step_nxt = cw.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: hw/rtl/acpu_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_dpath
// Datapath: instruction latch, data memory, ALU, restoring divider,
// architectural registers and the result register.
// ----------------------------------------------------------------------------
module acpu_dpath #(
  parameter int DATA_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_acc,
  input  logic [acpu_pkg::IN_W-1:0] in_tdata,
  input  acpu_pkg::ctrl_t           cw,
  output acpu_pkg::dp_sts_t         sts,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [acpu_pkg::OUT_W-1:0] out_tdata
);
  import acpu_pkg::*;

  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  // Operand modulo depth, worked out at elaboration
  logic [AW-1:0] mod_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = AW'(g % DATA_DEPTH);
  end

  logic [7:0] func_r, opnd_r, mq_r, acc_r, pc_r, rem_r, quo_r;
  logic       mv_r;
  logic [2:0] sts_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [7:0] mem [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] vld_r;
  logic       out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [7:0]  m, acc_nxt, pc_nxt, rem_nxt;
  logic [2:0]  sts_nxt;
  logic        halt, divz, ill, we, zupd, commit;
  logic [8:0]  sum9, dif9;
  logic [15:0] prod;
  logic [9:0]  trial;
  logic [AW-1:0] rd_addr, wr_addr;

  assign rd_addr = mod_tab[in_tdata[15:8]];
  assign wr_addr = mod_tab[opnd_r];
  assign m       = mv_r ? mq_r : 8'h00;
  assign commit  = cw.finish && sts.out_free;

  assign sts.is_div   = (func_r == {4'd0, OP_DIV});
  assign sts.m_zero   = (m == 8'h00);
  assign sts.div_more = (dcnt_r != DCNT_W'(DIV_STEPS - 1));
  assign sts.out_free = !out_valid_r || out_tready;

  // Latch the request and read the data memory
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_tdata[7:0];
      opnd_r <= in_tdata[15:8];
      mq_r   <= mem[rd_addr];
      mv_r   <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (commit && we) begin
      mem[wr_addr] <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (commit && we) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Restoring divider, one quotient bit per step
  assign trial   = {1'b0, rem_r, quo_r[7]} - {2'b00, m};
  assign rem_nxt = trial[9] ? {rem_r[6:0], quo_r[7]} : trial[7:0];

  always_ff @(posedge clk) begin
    if (cw.div_load) begin
      rem_r  <= 8'h00;
      quo_r  <= acc_r;
      dcnt_r <= '0;
    end else if (cw.div_step) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[6:0], ~trial[9]};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  assign sum9 = {1'b0, acc_r} + {1'b0, m};
  assign dif9 = {1'b0, acc_r} - {1'b0, m};
  assign prod = acc_r * m;

  always_comb begin
    acc_nxt = acc_r;
    sts_nxt = sts_r;
    pc_nxt  = pc_r + 8'd1;
    halt    = 1'b0;
    divz    = 1'b0;
    ill     = 1'b0;
    we      = 1'b0;
    zupd    = 1'b0;
    case (cw.res)
      RES_QUO: begin
        acc_nxt = quo_r;
        sts_nxt = {1'b0, 1'b0, (quo_r == 8'h00)};
      end
      RES_DIVZ: begin
        divz = 1'b1;
      end
      RES_ALU: begin
        if (func_r[7:4] != 4'd0) begin
          ill    = 1'b1;
          pc_nxt = pc_r;
        end else begin
          case (opc_t'(func_r[3:0]))
            OP_LDM: begin
              acc_nxt = m;
              zupd    = 1'b1;
            end
            OP_LDI: begin
              acc_nxt = opnd_r;
              zupd    = 1'b1;
            end
            OP_ST: begin
              we = 1'b1;
            end
            OP_ADD: begin
              acc_nxt           = sum9[7:0];
              sts_nxt[ST_CARRY] = sum9[8];
              zupd              = 1'b1;
            end
            OP_SUB: begin
              acc_nxt           = dif9[7:0];
              sts_nxt[ST_CARRY] = dif9[8];
              zupd              = 1'b1;
            end
            OP_MUL: begin
              acc_nxt          = prod[7:0];
              sts_nxt[ST_OVER] = |prod[15:8];
              zupd             = 1'b1;
            end
            OP_INC: begin
              acc_nxt           = acc_r + 8'd1;
              sts_nxt[ST_CARRY] = (acc_r == 8'hFF);
              zupd              = 1'b1;
            end
            OP_DEC: begin
              acc_nxt           = acc_r - 8'd1;
              sts_nxt[ST_CARRY] = 1'b0;
              sts_nxt[ST_OVER]  = 1'b0;
              zupd              = 1'b1;
            end
            OP_AND: begin
              acc_nxt = acc_r & m;
              zupd    = 1'b1;
            end
            OP_OR: begin
              acc_nxt = acc_r | m;
              zupd    = 1'b1;
            end
            OP_NOT: begin
              acc_nxt = ~acc_r;
              zupd    = 1'b1;
            end
            OP_JMP: begin
              pc_nxt = {1'b0, opnd_r[7:1]};
            end
            OP_JZ: begin
              if (acc_r == 8'h00) begin
                pc_nxt = {1'b0, opnd_r[7:1]};
              end
            end
            OP_JNZ: begin
              if (acc_r != 8'h00) begin
                pc_nxt = {1'b0, opnd_r[7:1]};
              end
            end
            OP_HALT: begin
              halt   = 1'b1;
              pc_nxt = pc_r;
            end
            default: begin
            end
          endcase
          if (zupd) begin
            sts_nxt[ST_ZERO] = (acc_nxt == 8'h00);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 8'h00;
      sts_r <= 3'b000;
      pc_r  <= 8'h00;
    end else if (commit) begin
      acc_r <= acc_nxt;
      sts_r <= sts_nxt;
      pc_r  <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= {2'b00, ill, divz, halt, pc_nxt, sts_nxt, acc_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hw/rtl/accumulator_cpu_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_execute
// Executes one instruction of an 8-bit accumulator machine per request and
// returns the new accumulator, status, next pc and event flags.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload (lsb first)                                 width
//   in_      in   func[7:0], operand[15:8]                             16
//   out_     out  accumulator[7:0], status[10:8], next_pc[18:11],      24
//                 halted[19], div_zero[20], illegal[21], zero[23:22]
//
// Sequence: one request at a time. Most opcodes go from accept to the result
// register through accept with memory read, dispatch and execute. DIV goes
// through accept, dispatch, divider seed, 8 restoring steps and writeback;
// a zero divisor exits after the seed step.
// Stalls: a finishing step holds while the previous result waits on
// out_tready; the next request is taken as soon as the result is loaded.
// Reset: clears the accumulator, status, pc and the per-byte valid bits of
// the data memory, so unwritten bytes read as zero; no clearing pass.
//
module accumulator_cpu_execute #(
  parameter int DATA_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [acpu_pkg::IN_W-1:0]  in_tdata,   // func[7:0], operand[15:8]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [acpu_pkg::OUT_W-1:0] out_tdata   // acc, status, next_pc,
                                                 // halted, div_zero, illegal
);
  import acpu_pkg::*;

  ctrl_t   cw;
  dp_sts_t sts;
  logic    in_acc;

  // Take requests only in the idle step, and never while reset is held
  assign in_tready = cw.take && rst_n;
  assign in_acc    = in_tvalid && in_tready;

  acpu_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_acc (in_acc),
    .sts    (sts),
    .cw     (cw)
  );

  acpu_dpath #(
    .DATA_DEPTH (DATA_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_tdata   (in_tdata),
    .cw         (cw),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hw/rtl/acpu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_chk
// Port-level checks for the accumulator CPU execute block.
// ----------------------------------------------------------------------------
module acpu_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [acpu_pkg::IN_W-1:0]  in_tdata,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [acpu_pkg::OUT_W-1:0] out_tdata
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One request in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // No result can appear the cycle after an accept
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result too early");

  // At most one event flag per result, fill bits zero
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[21:19]) && (out_tdata[23:22] == 2'b00))
    else $error("bad result flags");

  // Quiet in_tdata use: payload must be known when accepted
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !$isunknown(in_tdata))
    else $error("unknown request payload");

endmodule

bind accumulator_cpu_execute acpu_chk u_acpu_chk (.*);
